// ----- design/position_triggered_pulse_timestamper_core_macros.svh -----
// Assertion macros for the position triggered pulse timestamper.
// Included by the top level; no other dependencies.
`ifndef POSITION_TRIGGERED_PULSE_TIMESTAMPER_CORE_MACROS_SVH
`define POSITION_TRIGGERED_PULSE_TIMESTAMPER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PTPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PTPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PTPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define PTPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- design/ptpt_pkg.sv -----
// Shared types and constants of the position triggered pulse timestamper.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package ptpt_pkg;

	localparam int POS_WIDTH_DEF = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	localparam int ND_W   = 21;
	localparam int ON_W   = 20;
	localparam int PT_W   = 20;
	localparam int PL_W   = 31;
	localparam int TS_W   = 32;
	localparam int OFF_W  = 31;
	localparam int SEQ_W  = 8;
	localparam int MAG_W  = 32;
	localparam int PROD_W = PL_W + MAG_W - 1;
	localparam int CNT_W  = 5;

	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MAG_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(OFF_W - 1);
	localparam logic [OFF_W-1:0] OFF_MAX  = {OFF_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NETWORK_DELAY = 3'd0,
		CFG_ON_DELAY      = 3'd1,
		CFG_END_MODE      = 3'd2,
		CFG_PULSE_TIME    = 3'd3,
		CFG_PULSE_LENGTH  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] position;
		logic signed [31:0] trigger_position;
		logic               enable;
		logic signed [31:0] net_time;
		logic               edge_error_in;
		logic               edge_warning_in;
	} scan_t;

	typedef struct packed {
		logic signed [TS_W-1:0] pulse_timestamp;
		logic [ON_W-1:0]        on_delay_out;
		logic [OFF_W-1:0]       off_time;
		logic [SEQ_W-1:0]       sequence_res;
		logic                   enable_out;
		logic                   error_ack;
		logic                   warning_ack;
		logic                   module_error;
		logic                   edge_warning;
	} result_t;

endpackage

`default_nettype wire

// ----- design/ptpt_ifs.sv -----
// Valid/ready channel interfaces for scan requests and results.
// Depends on ptpt_pkg.
`default_nettype none

interface ptpt_scan_if;
	logic            valid;
	logic            ready;
	ptpt_pkg::scan_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ptpt_result_if;
	logic              valid;
	logic              ready;
	ptpt_pkg::result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/position_triggered_pulse_timestamper_core.sv -----
// Position triggered pulse timestamper, top level.
// Depends on ptpt_pkg, ptpt_ifs and the assertion macro header.
//
// One scan request in, one result out. A scan that does not fire the trigger
// passes through the prep state to the done state, where its result is
// registered. A firing scan runs the interpolation bit-serially, one bit of
// |dt| per cycle through a shared shift-and-subtract unit; in length mode,
// unless time runs backward, the product is then divided by a restoring
// divider at one quotient bit per cycle, and the division is skipped when
// the off time saturates. A new result waits in the done state while the
// previous one still waits on ready. The next scan is taken once the result
// is in the output register, while that result still waits.
`default_nettype none

`include "position_triggered_pulse_timestamper_core_macros.svh"

module position_triggered_pulse_timestamper_core #(
	parameter int POS_WIDTH = ptpt_pkg::POS_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ptpt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptpt_pkg::CFG_DATA_W-1:0] cfg_data,
	ptpt_scan_if.sink                       scan,
	ptpt_result_if.source                   result
);

	localparam int PW = (POS_WIDTH < 32) ? POS_WIDTH : 32;
	localparam int RW = ((PW > ptpt_pkg::OFF_W) ? PW : ptpt_pkg::OFF_W) + 2;
	localparam int TW = ptpt_pkg::TS_W;
	localparam int OW = ptpt_pkg::OFF_W;
	localparam int XW = ptpt_pkg::PROD_W;

	typedef enum logic [2:0] {
		S_IDLE, S_PREP, S_MAG, S_MUL, S_SAT, S_DIV, S_DONE
	} state_t;

	// configuration
	logic [ptpt_pkg::ND_W-1:0] nd_q;
	logic [ptpt_pkg::ON_W-1:0] on_delay_q;
	logic                      end_mode_q;
	logic [ptpt_pkg::PT_W-1:0] pulse_time_q;
	logic [ptpt_pkg::PL_W-1:0] pulse_len_q;

	// control and held state
	state_t                     state_q;
	logic signed [PW-1:0]       last_pos_q;
	logic [TW-1:0]              last_t_q;
	logic                       armed_q;
	logic                       prev_en_q;
	logic [TW-1:0]              held_ts_q;
	logic [ptpt_pkg::ON_W-1:0]  held_on_q;
	logic [OW-1:0]              held_off_q;
	logic [ptpt_pkg::SEQ_W-1:0] seq_q;
	logic                       err_ack_q;
	logic                       warn_ack_q;
	logic                       res_valid_q;
	ptpt_pkg::result_t          res_data_q;

	// datapath
	logic signed [PW-1:0]       pos_s1;
	logic signed [PW-1:0]       trig_s1;
	logic                       en_s1;
	logic [TW-1:0]              t_s1;
	logic                       err_s1;
	logic                       warn_s1;
	logic [TW-1:0]              d_q;
	logic [PW-1:0]              dist_q;
	logic [PW-1:0]              off_q;
	logic                       fire_q;
	logic                       merr_q;
	logic                       mwarn_q;
	logic                       dneg_q;
	logic [ptpt_pkg::MAG_W-1:0] mag_q;
	logic [RW-1:0]              r_q;
	logic [TW-1:0]              q_q;
	logic [XW-1:0]              p_q;
	logic [ptpt_pkg::CNT_W-1:0] cnt_q;
	logic                       sat_q;
	logic [OW-1:0]              dq_q;

	logic [TW-1:0]              t_c;
	logic [TW-1:0]              d_c;
	logic                       inside_c;
	logic                       fire_c;
	logic [PW-1:0]              dist_c;
	logic [PW-1:0]              off_c;
	logic [RW-1:0]              dist_ext;
	logic [RW-1:0]              dist2_ext;
	logic [RW-1:0]              r2;
	logic [RW-1:0]              r2d;
	logic [RW-1:0]              p_hi;
	logic                       sat_c;
	logic                       mbit;
	logic                       out_free;
	logic [TW-1:0]              ts_n;
	logic [OW-1:0]              off_n;

	assign t_c = scan.data.net_time + {{(TW - ptpt_pkg::ND_W){nd_q[ptpt_pkg::ND_W-1]}}, nd_q};

	assign d_c      = t_s1 - last_t_q;
	assign inside_c = (trig_s1 <= pos_s1) && (trig_s1 >= last_pos_q);
	assign fire_c   = inside_c && (pos_s1 != last_pos_q) && !armed_q && prev_en_q && en_s1;
	assign dist_c   = pos_s1 - last_pos_q;
	assign off_c    = trig_s1 - last_pos_q;

	assign dist_ext  = {{(RW - PW){1'b0}}, dist_q};
	assign dist2_ext = {dist_ext[RW-2:0], 1'b0};
	assign mbit      = mag_q[ptpt_pkg::MAG_W-1];
	assign r2 = {r_q[RW-2:0], 1'b0} + (mbit ? {{(RW - PW){1'b0}}, off_q} : RW'(0));
	assign r2d  = {r_q[RW-2:0], p_q[OW-1]};
	assign p_hi = {{(RW - (XW - OW)){1'b0}}, p_q[XW-1:OW]};
	assign sat_c = p_hi >= dist_ext;

	assign out_free = !res_valid_q || result.ready;

	assign ts_n = !fire_q ? held_ts_q : (dneg_q ? t_s1 - q_q : t_s1 + q_q);

	always_comb begin
		if (!fire_q) begin
			off_n = held_off_q;
		end else if (!end_mode_q) begin
			off_n = {{(OW - ptpt_pkg::PT_W){1'b0}}, pulse_time_q};
		end else if (dneg_q) begin
			off_n = '0;
		end else if (sat_q) begin
			off_n = ptpt_pkg::OFF_MAX;
		end else begin
			off_n = dq_q;
		end
	end

	assign scan.ready   = (state_q == S_IDLE);
	assign result.valid = res_valid_q;
	assign result.data  = res_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_q         <= '0;
			on_delay_q   <= '0;
			end_mode_q   <= 1'b0;
			pulse_time_q <= '0;
			pulse_len_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptpt_pkg::CFG_NETWORK_DELAY: nd_q <= cfg_data[ptpt_pkg::ND_W-1:0];
				ptpt_pkg::CFG_ON_DELAY:      on_delay_q <= cfg_data[ptpt_pkg::ON_W-1:0];
				ptpt_pkg::CFG_END_MODE:      end_mode_q <= cfg_data[0];
				ptpt_pkg::CFG_PULSE_TIME:    pulse_time_q <= cfg_data[ptpt_pkg::PT_W-1:0];
				ptpt_pkg::CFG_PULSE_LENGTH:  pulse_len_q <= cfg_data[ptpt_pkg::PL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_pos_q  <= '0;
			last_t_q    <= '0;
			armed_q     <= 1'b0;
			prev_en_q   <= 1'b0;
			held_ts_q   <= '0;
			held_on_q   <= '0;
			held_off_q  <= '0;
			seq_q       <= '0;
			err_ack_q   <= 1'b0;
			warn_ack_q  <= 1'b0;
			res_valid_q <= 1'b0;
			res_data_q  <= '0;
		end else begin
			if (res_valid_q && result.ready && state_q != S_DONE) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (scan.valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					last_t_q   <= t_s1;
					last_pos_q <= pos_s1;
					prev_en_q  <= en_s1;
					err_ack_q  <= err_s1;
					warn_ack_q <= warn_s1;
					if (fire_c) begin
						armed_q <= 1'b1;
					end else if (!inside_c) begin
						armed_q <= 1'b0;
					end
					state_q <= fire_c ? S_MAG : S_DONE;
				end
				S_MAG: state_q <= S_MUL;
				S_MUL: begin
					if (cnt_q == ptpt_pkg::MUL_LAST) begin
						state_q <= (end_mode_q && !dneg_q) ? S_SAT : S_DONE;
					end
				end
				S_SAT: state_q <= sat_c ? S_DONE : S_DIV;
				S_DIV: begin
					if (cnt_q == ptpt_pkg::DIV_LAST) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						if (fire_q) begin
							held_ts_q  <= ts_n;
							held_on_q  <= on_delay_q;
							held_off_q <= off_n;
							seq_q      <= seq_q + 1'b1;
						end
						res_data_q.pulse_timestamp <= ts_n;
						res_data_q.on_delay_out    <= fire_q ? on_delay_q : held_on_q;
						res_data_q.off_time        <= off_n;
						res_data_q.sequence_res    <= fire_q ? seq_q + 1'b1 : seq_q;
						res_data_q.enable_out      <= en_s1;
						res_data_q.error_ack       <= err_ack_q;
						res_data_q.warning_ack     <= warn_ack_q;
						res_data_q.module_error    <= merr_q;
						res_data_q.edge_warning    <= mwarn_q;
						res_valid_q                <= 1'b1;
						state_q                    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (scan.valid) begin
					pos_s1  <= scan.data.position[PW-1:0];
					trig_s1 <= scan.data.trigger_position[PW-1:0];
					en_s1   <= scan.data.enable;
					t_s1    <= t_c;
					err_s1  <= scan.data.edge_error_in;
					warn_s1 <= scan.data.edge_warning_in;
				end
			end
			S_PREP: begin
				d_q     <= d_c;
				dist_q  <= dist_c;
				off_q   <= off_c;
				fire_q  <= fire_c;
				merr_q  <= err_s1 && !err_ack_q;
				mwarn_q <= warn_s1 && !warn_ack_q;
			end
			S_MAG: begin
				dneg_q <= d_q[TW-1];
				mag_q  <= d_q[TW-1] ? (~d_q + 1'b1) : d_q;
				r_q    <= '0;
				q_q    <= '0;
				p_q    <= '0;
				cnt_q  <= '0;
			end
			S_MUL: begin
				mag_q <= {mag_q[ptpt_pkg::MAG_W-2:0], 1'b0};
				p_q   <= {p_q[XW-2:0], 1'b0} + (mbit ? {{(XW - ptpt_pkg::PL_W){1'b0}}, pulse_len_q}
				                                     : XW'(0));
				if (r2 >= dist2_ext) begin
					r_q <= r2 - dist2_ext;
					q_q <= {q_q[TW-2:0], 1'b0} + TW'(2);
				end else if (r2 >= dist_ext) begin
					r_q <= r2 - dist_ext;
					q_q <= {q_q[TW-2:0], 1'b1};
				end else begin
					r_q <= r2;
					q_q <= {q_q[TW-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
			end
			S_SAT: begin
				sat_q <= sat_c;
				r_q   <= p_hi;
				dq_q  <= '0;
				cnt_q <= '0;
			end
			S_DIV: begin
				p_q <= {p_q[XW-2:0], 1'b0};
				if (r2d >= dist_ext) begin
					r_q  <= r2d - dist_ext;
					dq_q <= {dq_q[OW-2:0], 1'b1};
				end else begin
					r_q  <= r2d;
					dq_q <= {dq_q[OW-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
			end
			S_DONE: ;
			default: ;
		endcase
	end

	`PTPT_ASSERT_NEXT(a_accept_prep, clk, arst_n, scan.valid && scan.ready,
		state_q == S_PREP, "accepted request did not enter prep")
	`PTPT_ASSERT_NOW(a_mul_rem, clk, arst_n, state_q == S_MUL, r_q < dist_ext,
		"interpolation remainder not below distance")
	`PTPT_ASSERT_NEXT(a_seq_step, clk, arst_n, state_q == S_DONE && fire_q && out_free,
		seq_q == ptpt_pkg::SEQ_W'($past(seq_q) + 1'b1), "sequence did not step on trigger")

endmodule

`default_nettype wire

// ----- tb/sv/position_triggered_pulse_timestamper_core_test.sv -----
// Self-checking testbench for position_triggered_pulse_timestamper_core.
// Drives scan requests, predicts each result in a scoreboard and compares them.
// Depends on ptpt_pkg, ptpt_ifs and the core RTL.

module position_triggered_pulse_timestamper_core_test;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int END_WAIT_CYCLES = 100;
	localparam int TIMEOUT         = 2000000;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [ptpt_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ptpt_pkg::CFG_DATA_W-1:0] cfg_data;

	ptpt_scan_if   scan_ch();
	ptpt_result_if result_ch();

	position_triggered_pulse_timestamper_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.scan(scan_ch),
		.result(result_ch)
	);

	// register copies
	logic [ptpt_pkg::ND_W-1:0]  cfg_net_delay  = '0;
	logic [ptpt_pkg::ON_W-1:0]  cfg_on_delay   = '0;
	logic                       cfg_len_mode   = 1'b0;
	logic [ptpt_pkg::PT_W-1:0]  cfg_pulse_time = '0;
	logic [ptpt_pkg::PL_W-1:0]  cfg_pulse_len  = '0;

	// timestamper state
	logic signed [31:0]          prev_pos     = '0;
	logic [31:0]                 prev_time    = '0;
	logic                        fired        = 1'b0;
	logic                        was_enabled  = 1'b0;
	logic [ptpt_pkg::TS_W-1:0]   ts_hold      = '0;
	logic [ptpt_pkg::ON_W-1:0]   on_hold      = '0;
	logic [ptpt_pkg::OFF_W-1:0]  off_hold     = '0;
	logic [ptpt_pkg::SEQ_W-1:0]  pulse_count  = '0;
	logic                        err_acked    = 1'b0;
	logic                        warn_acked   = 1'b0;

	ptpt_pkg::result_t pending[$];
	int                mismatches = 0;
	bit                sender_idle;
	bit                receiver_idle;
	bit                hold_off_req;

	// sweep generator state
	logic signed [31:0] sweep_pos;
	logic signed [31:0] sweep_trig;
	logic [31:0]        sweep_time;
	logic               sweep_err;
	logic               sweep_warn;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(TIMEOUT);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic ptpt_pkg::result_t predict_scan(ptpt_pkg::scan_t s);
		ptpt_pkg::result_t  r;
		logic signed [31:0] p;
		logic signed [31:0] tr;
		logic [31:0]        t;
		logic [31:0]        d;
		logic [31:0]        q;
		logic               d_neg;
		logic               between;
		longint unsigned    dmag;
		longint unsigned    span;
		longint unsigned    offs;
		longint unsigned    v;
		p = s.position;
		tr = s.trigger_position;
		t = s.net_time + {{(32-ptpt_pkg::ND_W){cfg_net_delay[ptpt_pkg::ND_W-1]}}, cfg_net_delay};
		d = t - prev_time;
		d_neg = d[31];
		dmag = d_neg ? (64'h1_0000_0000 - 64'(d)) : 64'(d);
		between = (tr <= p) && (tr >= prev_pos);
		if (between && p != prev_pos && !fired && was_enabled && s.enable) begin
			span = longint'(p) - longint'(prev_pos);
			offs = longint'(tr) - longint'(prev_pos);
			q = 32'((offs * dmag) / span);
			ts_hold = d_neg ? t - q : t + q;
			on_hold = cfg_on_delay;
			if (!cfg_len_mode) begin
				off_hold = ptpt_pkg::OFF_W'(cfg_pulse_time);
			end else if (d_neg) begin
				off_hold = '0;
			end else begin
				v = (64'(cfg_pulse_len) * dmag) / span;
				off_hold = (v > 64'(ptpt_pkg::OFF_MAX)) ? ptpt_pkg::OFF_MAX
				                                         : v[ptpt_pkg::OFF_W-1:0];
			end
			fired = 1'b1;
			pulse_count = pulse_count + 1'b1;
		end
		if (!between)
			fired = 1'b0;
		was_enabled = s.enable;
		prev_pos = p;
		prev_time = t;
		r.module_error = 1'b0;
		r.edge_warning = 1'b0;
		if (s.edge_error_in && !err_acked) begin
			err_acked = 1'b1;
			r.module_error = 1'b1;
		end else if (!s.edge_error_in) begin
			err_acked = 1'b0;
		end
		if (s.edge_warning_in && !warn_acked) begin
			warn_acked = 1'b1;
			r.edge_warning = 1'b1;
		end else if (!s.edge_warning_in) begin
			warn_acked = 1'b0;
		end
		r.pulse_timestamp = ts_hold;
		r.on_delay_out = on_hold;
		r.off_time = off_hold;
		r.sequence_res = pulse_count;
		r.enable_out = s.enable;
		r.error_ack = err_acked;
		r.warning_ack = warn_acked;
		return r;
	endfunction

	function automatic void check_result(ptpt_pkg::result_t got, ptpt_pkg::result_t want);
		if (got.pulse_timestamp !== want.pulse_timestamp || got.on_delay_out !== want.on_delay_out
				|| got.off_time !== want.off_time || got.sequence_res !== want.sequence_res
				|| got.enable_out !== want.enable_out || got.error_ack !== want.error_ack
				|| got.warning_ack !== want.warning_ack || got.module_error !== want.module_error
				|| got.edge_warning !== want.edge_warning) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch: exp ts=%0d on=%0d off=%0d seq=%0d en/ea/wa/me/ew=%b%b%b%b%b",
					want.pulse_timestamp, want.on_delay_out, want.off_time, want.sequence_res,
					want.enable_out, want.error_ack, want.warning_ack, want.module_error,
					want.edge_warning);
				$display("          got ts=%0d on=%0d off=%0d seq=%0d en/ea/wa/me/ew=%b%b%b%b%b",
					got.pulse_timestamp, got.on_delay_out, got.off_time, got.sequence_res,
					got.enable_out, got.error_ack, got.warning_ack, got.module_error,
					got.edge_warning);
			end
		end
	endfunction

	// result check first, then the new request, so order within an edge is fixed
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (pending.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result at %0t", $realtime);
				end else begin
					check_result(result_ch.data, pending.pop_front());
				end
			end
			if (scan_ch.valid && scan_ch.ready)
				pending.push_back(predict_scan(scan_ch.data));
		end
	end

	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	function automatic ptpt_pkg::scan_t make_scan(logic signed [31:0] pos,
			logic signed [31:0] trig, logic en, logic [31:0] nt, logic err, logic warn);
		ptpt_pkg::scan_t s;
		s.position = pos;
		s.trigger_position = trig;
		s.enable = en;
		s.net_time = nt;
		s.edge_error_in = err;
		s.edge_warning_in = warn;
		return s;
	endfunction

	task automatic send_scan(ptpt_pkg::scan_t s);
		if (sender_idle && $urandom_range(0, 5) == 0) begin
			scan_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		scan_ch.valid <= 1'b1;
		scan_ch.data <= s;
		do @(posedge clk); while (!scan_ch.ready);
	endtask

	task automatic drain_results();
		scan_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_config(logic [ptpt_pkg::ND_W-1:0] nd, logic [ptpt_pkg::ON_W-1:0] on_dly,
			logic len_mode, logic [ptpt_pkg::PT_W-1:0] pt, logic [ptpt_pkg::PL_W-1:0] pl);
		cfg_we <= 1'b1;
		cfg_index <= ptpt_pkg::CFG_NETWORK_DELAY;
		cfg_data <= ptpt_pkg::CFG_DATA_W'(nd);
		@(posedge clk);
		cfg_index <= ptpt_pkg::CFG_ON_DELAY;
		cfg_data <= ptpt_pkg::CFG_DATA_W'(on_dly);
		@(posedge clk);
		cfg_index <= ptpt_pkg::CFG_END_MODE;
		cfg_data <= ptpt_pkg::CFG_DATA_W'(len_mode);
		@(posedge clk);
		cfg_index <= ptpt_pkg::CFG_PULSE_TIME;
		cfg_data <= ptpt_pkg::CFG_DATA_W'(pt);
		@(posedge clk);
		cfg_index <= ptpt_pkg::CFG_PULSE_LENGTH;
		cfg_data <= ptpt_pkg::CFG_DATA_W'(pl);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cfg_net_delay = nd;
		cfg_on_delay = on_dly;
		cfg_len_mode = len_mode;
		cfg_pulse_time = pt;
		cfg_pulse_len = pl;
	endtask

	// forward sweeps toward a moving trigger mark, with some reversal, stops and noise
	task automatic run_sweep(int count);
		ptpt_pkg::scan_t s;
		logic [31:0]     stride;
		int unsigned     span_max;
		span_max = 16;
		for (int i = 0; i < count; i++) begin
			if (i % 20 == 0)
				span_max = 1 << $urandom_range(2, 28);
			if ($urandom_range(0, 9) == 0) begin
				s.position = $urandom;
				s.trigger_position = $urandom;
				s.net_time = $urandom;
				s.enable = 1'($urandom);
				s.edge_error_in = 1'($urandom);
				s.edge_warning_in = 1'($urandom);
			end else begin
				if (sweep_trig < sweep_pos)
					sweep_trig = sweep_pos + $urandom_range(0, 3 * span_max);
				case ($urandom_range(0, 15))
					0: stride = '0;
					1: stride = -$urandom_range(1, span_max);
					default: stride = $urandom_range(1, span_max);
				endcase
				sweep_pos = sweep_pos + stride;
				if ($urandom_range(0, 29) == 0)
					sweep_time = $urandom;
				else
					sweep_time = sweep_time + $urandom_range(1, 2000);
				if ($urandom_range(0, 3) == 0)
					sweep_err = ~sweep_err;
				if ($urandom_range(0, 3) == 0)
					sweep_warn = ~sweep_warn;
				s = make_scan(sweep_pos, sweep_trig, $urandom_range(0, 19) != 0, sweep_time,
					sweep_err, sweep_warn);
			end
			send_scan(s);
		end
	endtask

	task automatic test_time_mode();
		load_config(ptpt_pkg::ND_W'(1000000), 20'd1000000, 1'b0, 20'd1000000, '0);
		send_scan(make_scan(0, 0, 1'b1, 1000, 1'b0, 1'b0));
		send_scan(make_scan(100, 50, 1'b1, 2000, 1'b0, 1'b0));
		send_scan(make_scan(200, 500, 1'b1, 3000, 1'b0, 1'b0));
		// trigger at the new position while time runs backward
		send_scan(make_scan(500, 500, 1'b1, 2500, 1'b0, 1'b0));
		send_scan(make_scan(500, 500, 1'b1, 2600, 1'b0, 1'b0));
		send_scan(make_scan(400, 450, 1'b1, 2700, 1'b0, 1'b0));
		// trigger at the previous position
		send_scan(make_scan(600, 400, 1'b1, 2800, 1'b0, 1'b0));
		send_scan(make_scan(32'h8000_0000, 0, 1'b1, 32'h7FFF_FFF0, 1'b0, 1'b0));
		send_scan(make_scan(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h8000_0010, 1'b0, 1'b0));
		send_scan(make_scan(0, 10, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0));
		send_scan(make_scan(20, 10, 1'b1, 100, 1'b0, 1'b0));
		send_scan(make_scan(40, 30, 1'b1, 200, 1'b0, 1'b0));
	endtask

	task automatic test_length_mode();
		drain_results();
		load_config(ptpt_pkg::ND_W'(-1000000), 20'hFFFFF, 1'b1, 20'hFFFFF, ptpt_pkg::OFF_MAX);
		send_scan(make_scan(0, 100, 1'b1, 0, 1'b0, 1'b0));
		// short span, long pulse: off time saturates
		send_scan(make_scan(10, 5, 1'b1, 50, 1'b0, 1'b0));
		send_scan(make_scan(100, 500, 1'b1, 100, 1'b0, 1'b0));
		send_scan(make_scan(1000, 600, 1'b1, 40, 1'b0, 1'b0));
		send_scan(make_scan(900, 2000, 1'b1, 60, 1'b0, 1'b0));
		send_scan(make_scan(2000, 1500, 1'b1, 32'h8000_003C, 1'b0, 1'b0));
	endtask

	task automatic test_ack_flags();
		send_scan(make_scan(2000, 0, 1'b1, 100, 1'b1, 1'b0));
		send_scan(make_scan(2000, 0, 1'b1, 200, 1'b1, 1'b1));
		send_scan(make_scan(2000, 0, 1'b1, 300, 1'b0, 1'b1));
		send_scan(make_scan(2000, 0, 1'b1, 400, 1'b1, 1'b0));
		send_scan(make_scan(2000, 0, 1'b0, 500, 1'b0, 1'b0));
		send_scan(make_scan(2000, 0, 1'b1, 600, 1'b1, 1'b1));
	endtask

	task automatic test_backpressure();
		drain_results();
		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		hold_off_req = 1'b1;
		run_sweep(16);
		drain_results();
		sender_idle = 1'b1;
		receiver_idle = 1'b1;
	endtask

	task automatic test_random_sweeps();
		for (int ph = 0; ph < 5; ph++) begin
			drain_results();
			case (ph)
				1: load_config(21'h100000, '0, 1'b1, '0, '0);
				3: load_config(21'h0FFFFF, 20'hFFFFF, 1'b1, 20'hFFFFF, ptpt_pkg::OFF_MAX);
				default: load_config(ptpt_pkg::ND_W'($urandom), ptpt_pkg::ON_W'($urandom),
					1'($urandom), ptpt_pkg::PT_W'($urandom), ptpt_pkg::PL_W'($urandom));
			endcase
			sender_idle = (ph != 4);
			receiver_idle = (ph != 4);
			run_sweep(76);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= ptpt_pkg::CFG_NETWORK_DELAY;
		cfg_data <= '0;
		scan_ch.valid <= 1'b0;
		scan_ch.data <= '0;
		sender_idle = 1'b1;
		receiver_idle = 1'b1;
		hold_off_req = 1'b0;
		sweep_pos = '0;
		sweep_trig = 32'sd1000;
		sweep_time = '0;
		sweep_err = 1'b0;
		sweep_warn = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_time_mode();
		test_length_mode();
		test_ack_flags();
		test_backpressure();
		test_random_sweeps();
		drain_results();
		repeat (END_WAIT_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
